// ===== hdl/knnmv_pkg.sv =====
// Shared constants and types of the k-nearest-neighbour majority vote.
`default_nettype none

package knnmv_pkg;

   // Table depth (largest k) and label width.
   localparam int K_MAX       = 16;
   localparam int LABEL_WIDTH = 32;

   // Width of the k register as seen on the configuration port.
   localparam int CSR_WIDTH   = 5;

   // Counts and positions must hold the value K_MAX itself.
   localparam int COUNT_WIDTH = $clog2(K_MAX + 1);

   // One table entry as held by a cell.
   typedef struct packed {
      logic                          valid;
      logic signed [LABEL_WIDTH-1:0] label;
      logic [COUNT_WIDTH-1:0]        count;
   } entry_type;

   localparam entry_type EMPTY_ENTRY = '0;

   // Broadcast commands from the controller to every cell.
   typedef struct packed {
      logic scan;   // shift the table towards cell 0 by one place
      logic bump;   // the new label is present: the matching cell counts up
      logic place;  // the new label is absent: sorted insert
   } cell_cmd_type;

endpackage

`default_nettype wire

// ===== hdl/knnmv_cell.sv =====
// One cell of the sorted label table: a label, its count and a valid bit.
`default_nettype none

module knnmv_cell
   import knnmv_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire cell_cmd_type                  cmd,
   input  wire logic signed [LABEL_WIDTH-1:0] new_label,
   input  wire entry_type                     left_entry,
   input  wire logic                          left_greater,
   input  wire entry_type                     right_entry,
   output entry_type                          entry,
   output logic                               greater,
   output logic                               match
);

   logic                          valid_ff, valid_in;
   logic signed [LABEL_WIDTH-1:0] label_ff, label_in;
   logic [COUNT_WIDTH-1:0]        count_ff, count_in;

   // An empty cell counts as holding a label above every other one.
   assign greater = !valid_ff || (label_ff > new_label);
   assign match   = valid_ff && (label_ff == new_label);

   assign entry = {valid_ff, label_ff, count_ff};

   // Next contents: scan shift, count increment or sorted insert.
   always_comb begin
      valid_in = valid_ff;
      label_in = label_ff;
      count_in = count_ff;
      if (cmd.scan) begin
         valid_in = right_entry.valid;
         label_in = right_entry.label;
         count_in = right_entry.count;
      end else if (cmd.bump) begin
         if (match) begin
            count_in = COUNT_WIDTH'(count_ff + 1'b1);
         end
      end else if (cmd.place && greater) begin
         if (left_greater) begin
            // The insert point lies further left: make room by shifting right.
            valid_in = left_entry.valid;
            label_in = left_entry.label;
            count_in = left_entry.count;
         end else begin
            // This is the first cell above the new label: it takes the label.
            valid_in = 1'b1;
            label_in = new_label;
            count_in = COUNT_WIDTH'(1);
         end
      end
   end

   // Valid bit is control state; label and count are payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      label_ff <= label_in;
      count_ff <= count_in;
   end

endmodule

`default_nettype wire

// ===== hdl/knn_majority_vote.sv =====
// Top level of the k-nearest-neighbour majority vote: cell chain, control and result register.
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_valid/req_stall   req_label (signed, LABEL_WIDTH)
//   rsp_      out        rsp_valid/rsp_stall   rsp_winning_label (signed, LABEL_WIDTH)
//   csr_      in         csr_write_enable      csr_write_data (k, CSR_WIDTH bits)
//
// Within a sample one label is taken every cycle; every cell compares it with its own label.
// After the k-th label the table is shifted out through cell 0 to find the winner.
// A result waiting in the output register does not hold up the next sample's labels;
// only a second result finding the register still occupied waits for it to be taken.
// Reset clears the valid bits and the control state at once; no clearing pass is needed.
`default_nettype none

module knn_majority_vote
   import knnmv_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [LABEL_WIDTH-1:0] req_label,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed [LABEL_WIDTH-1:0]      rsp_winning_label,
   input  wire logic                          csr_write_enable,
   input  wire logic [CSR_WIDTH-1:0]          csr_write_data
);

   typedef enum logic [1:0] {ST_ACCEPT, ST_SCAN, ST_DELIVER} state_type;

   state_type                     state_ff;
   logic [CSR_WIDTH-1:0]          neighbour_count_ff;
   logic [COUNT_WIDTH-1:0]        position_ff;
   logic                          best_valid_ff;
   logic signed [LABEL_WIDTH-1:0] best_label_ff;
   logic [COUNT_WIDTH-1:0]        best_count_ff;
   logic                          rsp_valid_ff;
   logic signed [LABEL_WIDTH-1:0] rsp_label_ff;

   entry_type                     entries [K_MAX];
   logic [K_MAX-1:0]              greater_vec;
   logic [K_MAX-1:0]              match_vec;
   logic [K_MAX-1:0]              valid_vec;
   cell_cmd_type                  cmd;
   logic [COUNT_WIDTH-1:0]        k_eff;
   logic                          accept;
   logic                          sample_last;
   logic                          out_free;
   logic                          deliver;
   logic                          table_ok;

   // Configuration register for k.
   always_ff @(posedge clock) begin
      if (reset) begin
         neighbour_count_ff <= CSR_WIDTH'(1);
      end else if (csr_write_enable) begin
         neighbour_count_ff <= csr_write_data;
      end
   end

   // Effective k: zero acts as one, values above the table depth saturate.
   always_comb begin
      if (neighbour_count_ff == '0) begin
         k_eff = COUNT_WIDTH'(1);
      end else if (32'(neighbour_count_ff) > 32'(K_MAX)) begin
         k_eff = COUNT_WIDTH'(K_MAX);
      end else begin
         k_eff = COUNT_WIDTH'(neighbour_count_ff);
      end
   end

   assign req_stall   = (state_ff != ST_ACCEPT);
   assign accept      = req_valid && !req_stall;
   assign sample_last = (32'(position_ff) + 32'd1) >= 32'(k_eff);
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   // The winner moves to the output register once the scan is over and the register is free.
   assign deliver = out_free &&
                    (((state_ff == ST_SCAN) && !entries[0].valid) || (state_ff == ST_DELIVER));

   // Commands broadcast to the cells.
   always_comb begin
      cmd.scan  = (state_ff == ST_SCAN) && entries[0].valid;
      cmd.bump  = accept && (|match_vec);
      cmd.place = accept && !(|match_vec) && !entries[K_MAX-1].valid;
   end

   // The chain of cells; each sees its left neighbour for inserts, its right one for scans.
   for (genvar i = 0; i < K_MAX; i++) begin : g_cell
      entry_type left_entry;
      entry_type right_entry;
      logic      left_greater;

      if (i == 0) begin : g_head
         assign left_entry   = EMPTY_ENTRY;
         assign left_greater = 1'b0;
      end else begin : g_body
         assign left_entry   = entries[i-1];
         assign left_greater = greater_vec[i-1];
      end

      if (i == K_MAX - 1) begin : g_tail
         assign right_entry = EMPTY_ENTRY;
      end else begin : g_inner
         assign right_entry = entries[i+1];
      end

      knnmv_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .cmd          (cmd),
         .new_label    (req_label),
         .left_entry   (left_entry),
         .left_greater (left_greater),
         .right_entry  (right_entry),
         .entry        (entries[i]),
         .greater      (greater_vec[i]),
         .match        (match_vec[i])
      );

      assign valid_vec[i] = entries[i].valid;
   end

   // Sequencer: collect labels, scan for the first maximum, hand over the result.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_ACCEPT;
         position_ff   <= '0;
         best_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (deliver) begin
            rsp_valid_ff <= 1'b1;
            rsp_label_ff <= best_label_ff;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_ACCEPT: begin
               if (accept) begin
                  if (sample_last) begin
                     position_ff   <= '0;
                     best_valid_ff <= 1'b0;
                     state_ff      <= ST_SCAN;
                  end else begin
                     position_ff <= COUNT_WIDTH'(position_ff + 1'b1);
                  end
               end
            end
            ST_SCAN: begin
               if (entries[0].valid) begin
                  // Strictly greater only, so the smallest label keeps a tie.
                  if (!best_valid_ff || (entries[0].count > best_count_ff)) begin
                     best_valid_ff <= 1'b1;
                     best_label_ff <= entries[0].label;
                     best_count_ff <= entries[0].count;
                  end
               end else if (out_free) begin
                  state_ff <= ST_ACCEPT;
               end else begin
                  state_ff <= ST_DELIVER;
               end
            end
            ST_DELIVER: begin
               if (out_free) begin
                  state_ff <= ST_ACCEPT;
               end
            end
            default: begin
               state_ff <= ST_ACCEPT;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_winning_label = rsp_label_ff;

   // Table shape: valid entries form a prefix and their labels strictly ascend.
   always_comb begin
      table_ok = 1'b1;
      for (int i = 0; i < K_MAX - 1; i++) begin
         if (valid_vec[i+1] && (!valid_vec[i] || !(entries[i].label < entries[i+1].label))) begin
            table_ok = 1'b0;
         end
      end
   end

   // The cell table stays a sorted prefix at all times.
   a_table_sorted : assert property (@(posedge clock) disable iff (reset)
      table_ok)
      else $error("cell table lost its sorted prefix shape");

   // While collecting, there are never more distinct labels than labels received.
   a_distinct_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACCEPT) |-> ($countones(valid_vec) <= 32'(position_ff)))
      else $error("more distinct labels than labels received in this sample");

   // The k-th label of a sample starts the winner scan.
   a_last_starts_scan : assert property (@(posedge clock) disable iff (reset)
      (accept && sample_last) |=> (state_ff == ST_SCAN))
      else $error("sample end did not start the winner scan");

endmodule

`default_nettype wire

// ===== verif/knn_majority_vote_checker.sv =====
// Checker of the k-nearest-neighbour majority vote: predicts every winning label and compares.
`default_nettype none

module knn_majority_vote_checker
   import knnmv_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_stall,
   input  wire logic signed [LABEL_WIDTH-1:0] req_label,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   input  wire logic signed [LABEL_WIDTH-1:0] rsp_winning_label,
   input  wire logic                          csr_write_enable,
   input  wire logic [CSR_WIDTH-1:0]          csr_write_data,
   output int                                 failures,
   output int                                 outstanding
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   // Predicted table of the sample in progress, kept in ascending signed label order.
   logic signed [LABEL_WIDTH-1:0] sorted_labels [K_MAX];
   logic [COUNT_WIDTH-1:0]        label_tally   [K_MAX];
   int                            distinct_labels  = 0;
   int                            labels_in_sample = 0;
   logic [CSR_WIDTH-1:0]          k_setting        = 1;

   // Winning labels still owed by the block, oldest first.
   logic signed [LABEL_WIDTH-1:0] expected_winners [$];
   int                            mismatch_count = 0;

   // Labels per sample: zero counts as one, anything above the table depth saturates.
   function automatic int votes_per_sample();
      int k;
      k = k_setting;
      if (k == 0) k = 1;
      if (k > K_MAX) k = K_MAX;
      return k;
   endfunction

   // Sorted insert: count up a label already present, else open a slot in order.
   function automatic void tally_label(input logic signed [LABEL_WIDTH-1:0] lab);
      int slot;
      slot = 0;
      while (slot < distinct_labels && !(lab < sorted_labels[slot])) slot++;
      if (slot > 0 && sorted_labels[slot-1] == lab) begin
         label_tally[slot-1]++;
         return;
      end
      if (distinct_labels >= K_MAX) return;
      for (int i = distinct_labels; i > slot; i--) begin
         sorted_labels[i] = sorted_labels[i-1];
         label_tally[i]   = label_tally[i-1];
      end
      sorted_labels[slot] = lab;
      label_tally[slot]   = 1;
      distinct_labels++;
   endfunction

   // The first maximum in label order wins, so ties go to the smallest label.
   function automatic logic signed [LABEL_WIDTH-1:0] majority_label();
      int best;
      best = 0;
      for (int i = 1; i < distinct_labels; i++) begin
         if (label_tally[i] > label_tally[best]) best = i;
      end
      return sorted_labels[best];
   endfunction

   // The result transaction first, then the label transaction, then register writes:
   // a label accepted at this edge cannot already have its result on the output, and
   // a register write at this edge only applies to later labels.
   always @(posedge clock) begin : watch
      logic signed [LABEL_WIDTH-1:0] wanted;
      if (reset) begin
         distinct_labels  = 0;
         labels_in_sample = 0;
         k_setting        = 1;
         expected_winners.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_winners.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%t: winning label %0d arrived with none expected",
                           $realtime, rsp_winning_label);
            end else begin
               wanted = expected_winners.pop_front();
               if (rsp_winning_label !== wanted) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display("%t: winning label expected %0d, actual %0d",
                              $realtime, wanted, rsp_winning_label);
               end
            end
         end

         if (req_valid && !req_stall) begin
            tally_label(req_label);
            labels_in_sample++;
            // A lowered k can end the sample at once, hence reach or pass.
            if (labels_in_sample >= votes_per_sample()) begin
               expected_winners.push_back(majority_label());
               distinct_labels  = 0;
               labels_in_sample = 0;
            end
         end

         if (csr_write_enable) k_setting = csr_write_data;
      end
      failures    <= mismatch_count;
      outstanding <= expected_winners.size();
   end

endmodule

`default_nettype wire

// ===== verif/knn_majority_vote_test.sv =====
// Testbench top of the k-nearest-neighbour majority vote: stimulus, idling and verdict.
`default_nettype none

module knn_majority_vote_test;

   import knnmv_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LABEL_GOAL  = 1300;
   localparam int CALM_FROM   = 1150;
   localparam int SETTLE_WAIT = 40;  // longer than a full table scan plus the output register

   localparam logic signed [LABEL_WIDTH-1:0] LABEL_MIN = {1'b1, {(LABEL_WIDTH-1){1'b0}}};
   localparam logic signed [LABEL_WIDTH-1:0] LABEL_MAX = {1'b0, {(LABEL_WIDTH-1){1'b1}}};

   logic                          clock;
   logic                          reset            = 1'b1;
   logic                          req_valid        = 1'b0;
   logic                          req_stall;
   logic signed [LABEL_WIDTH-1:0] req_label        = '0;
   logic                          rsp_valid;
   logic                          rsp_stall        = 1'b0;
   logic signed [LABEL_WIDTH-1:0] rsp_winning_label;
   logic                          csr_write_enable = 1'b0;
   logic [CSR_WIDTH-1:0]          csr_write_data   = '0;

   int failures;
   int outstanding;

   // Idling switches, changed per phase by the stimulus.
   bit sender_gaps    = 1'b0;
   bit receiver_stall = 1'b0;

   // Label mix of the current phase: a window of nearby labels, sometimes anything at all.
   logic signed [LABEL_WIDTH-1:0] window_base = '0;
   int                            window_size = 4;
   int                            labels_sent = 0;

   knn_majority_vote u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_label         (req_label),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_winning_label (rsp_winning_label),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   knn_majority_vote_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_label         (req_label),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_winning_label (rsp_winning_label),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .failures          (failures),
      .outstanding       (outstanding)
   );

   // 50 MHz clock.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Result side back-pressure in bursts of random length.
   initial begin
      forever begin
         if (receiver_stall && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
      end
   end

   // Offer one label and hold it until the block takes the transaction.
   task automatic send_label(input logic signed [LABEL_WIDTH-1:0] lab);
      if (sender_gaps && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_label <= lab;
      do @(posedge clock); while (req_stall);
      labels_sent++;
   endtask

   // Write k once the block owes nothing and any table scan has finished.
   task automatic write_k(input logic [CSR_WIDTH-1:0] k);
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_WAIT) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= k;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic signed [LABEL_WIDTH-1:0] random_label();
      case ($urandom_range(0, 9))
         0:       return $urandom;
         1:       return $urandom_range(0, 1) ? LABEL_MIN : LABEL_MAX;
         default: return window_base + $urandom_range(0, window_size - 1);
      endcase
   endfunction

   // Main stimulus: directed samples, then random phases, each with its own k.
   initial begin
      int phase;
      int phase_length;
      logic [CSR_WIDTH-1:0] next_k;
      logic [CSR_WIDTH-1:0] k_plan [10] = '{3, 16, 31, 1, 17, 0, 9, 2, 16, 5};

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // k from reset is one: every extreme label is its own winner.
      send_label(LABEL_MIN);
      send_label(LABEL_MAX);
      send_label('0);
      send_label(-1);

      // k of zero behaves as one.
      write_k(0);
      send_label(32'sd12345);

      // A two-way tie goes to the smaller, negative label.
      write_k(5);
      send_label(3);
      send_label(-3);
      send_label(3);
      send_label(-3);
      send_label(7);

      // A tie between the extremes goes to the most negative label.
      write_k(4);
      send_label(LABEL_MAX);
      send_label(LABEL_MIN);
      send_label(LABEL_MIN);
      send_label(LABEL_MAX);

      // Lowering k below the labels already held ends the sample on the next label.
      write_k(8);
      send_label(9);
      send_label(-9);
      send_label(9);
      write_k(2);
      send_label(-9);

      // Random phases; the last stretch runs with no idling on either side.
      phase = 0;
      while (labels_sent < LABEL_GOAL) begin
         next_k = (phase < 10) ? k_plan[phase] : CSR_WIDTH'($urandom_range(0, 31));
         write_k(next_k);
         window_size = $urandom_range(1, 20);
         window_base = $urandom_range(0, 3) == 0 ? $urandom : $signed($urandom_range(0, 8)) - 4;
         if (labels_sent >= CALM_FROM) begin
            sender_gaps    = 1'b0;
            receiver_stall = 1'b0;
         end else begin
            sender_gaps    = $urandom_range(0, 3) != 0;
            receiver_stall = $urandom_range(0, 3) != 0;
         end
         phase_length = $urandom_range(40, 140);
         repeat (phase_length) begin
            if (labels_sent < LABEL_GOAL) send_label(random_label());
         end
         phase++;
      end
      req_valid <= 1'b0;

      // Drain, then allow the last scan time to show any stray result.
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_WAIT + 20) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest correct run.
   initial begin
      #20_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

`default_nettype wire
